[hw/rtl/tmas_pkg.sv]
// shared types, constants and helpers for the trimmed-mean converter scanner
package tmas_pkg;

	localparam int SAMPLES    = 10;
	localparam int SLOTS      = 3;
	localparam int NUM_REGS   = 3;
	localparam int SAMPLE_W   = 12;
	localparam int CHAN_W     = 4;
	localparam int SLOT_OUT_W = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int REG_IDX_W  = $clog2(NUM_REGS);
	localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W      = $clog2(SAMPLES + 1);
	localparam int SUM_W      = $clog2(SAMPLES * ((1 << SAMPLE_W) - 1) + 1);
	localparam int TRIM_DIV   = SAMPLES - 2;
	localparam int MAX_CHANNEL = 8;

	typedef logic [SAMPLE_W-1:0]   sample_t;
	typedef logic [CHAN_W-1:0]     chan_t;
	typedef logic [SLOT_W-1:0]     slot_t;
	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
	typedef chan_t [NUM_REGS-1:0]  chan_regs_t;

	// reset channel of each register slot
	localparam chan_t CHAN_RESET [NUM_REGS] = '{4'd0, 4'd1, 4'd2};

	// mux channel for a slot: registered slots read their register, others use the slot number
	function automatic chan_t channel_of(chan_regs_t chans, slot_t s);
		logic [REG_IDX_W+SLOT_W-1:0] wide;
		chan_t ch;
		wide = (REG_IDX_W + SLOT_W)'(s);
		if (int'(s) < NUM_REGS) begin
			ch = chans[wide[REG_IDX_W-1:0]];
		end else begin
			ch = CHAN_W'(s);
		end
		return ch;
	endfunction

endpackage

[hw/rtl/tmas_cfg_regs.sv]
// configuration register file holding the mux channel of each slot
module tmas_cfg_regs (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  tmas_pkg::cfg_idx_t   cfg_index,
	input  tmas_pkg::chan_t      cfg_data,
	output tmas_pkg::chan_regs_t chans
);
	import tmas_pkg::*;

	chan_regs_t chans_q;

	// writes are always taken
	assign cfg_ready = 1'b1;
	assign chans     = chans_q;

	// register writes; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				chans_q[i] <= CHAN_RESET[i];
			end
		end else if (cfg_valid && cfg_ready) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				if (int'(cfg_index) == i) begin
					chans_q[i] <= cfg_data;
				end
			end
		end
	end

endmodule

[hw/rtl/tmas_accum.sv]
// input register, min/max/sum accumulators and result register
module tmas_accum (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  tmas_pkg::sample_t        sample,
	input  tmas_pkg::chan_regs_t     chans,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [1:0]               slot,
	output tmas_pkg::sample_t        filtered_value,
	output logic                     sweep_done,
	output tmas_pkg::chan_t          next_mux_channel
);
	import tmas_pkg::*;

	logic              valid_s1;
	sample_t           sample_s1;
	sample_t           min_q;
	sample_t           max_q;
	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  cnt_q;
	slot_t             slot_q;
	chan_t             mux_q;
	logic              out_valid_q;
	logic [1:0]        slot_out_q;
	sample_t           value_q;
	logic              done_q;

	sample_t           min_nxt;
	sample_t           max_nxt;
	logic [SUM_W-1:0]  sum_nxt;
	logic [SUM_W-1:0]  trimmed;
	logic              is_last;
	logic              done;
	slot_t             slot_nxt;
	chan_t             ch;
	chan_t             mux_nxt;
	logic              advance;
	logic              load_out;

	// accumulator step for the beat in the input register
	always_comb begin
		min_nxt  = (sample_s1 < min_q) ? sample_s1 : min_q;
		max_nxt  = (sample_s1 > max_q) ? sample_s1 : max_q;
		sum_nxt  = sum_q + SUM_W'(sample_s1);
		trimmed  = sum_nxt - SUM_W'(min_nxt) - SUM_W'(max_nxt);
		is_last  = (cnt_q == CNT_W'(SAMPLES - 1));
		done     = (slot_q == SLOT_W'(SLOTS - 1));
		slot_nxt = done ? '0 : slot_q + 1'b1;
		ch       = channel_of(chans, slot_nxt);
		mux_nxt  = (int'(ch) <= MAX_CHANNEL) ? ch : mux_q;
	end

	// a beat moves on unless it makes a result and the result register is held
	assign advance  = valid_s1 && (!is_last || !out_valid_q || !out_stall);
	assign load_out = advance && is_last;
	assign in_stall = valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			sample_s1 <= sample;
		end
	end

	// accumulators, slot and mux state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q  <= '1;
			max_q  <= '0;
			sum_q  <= '0;
			cnt_q  <= '0;
			slot_q <= '0;
			mux_q  <= '0;
		end else if (advance) begin
			if (is_last) begin
				min_q  <= '1;
				max_q  <= '0;
				sum_q  <= '0;
				cnt_q  <= '0;
				slot_q <= slot_nxt;
				mux_q  <= mux_nxt;
			end else begin
				min_q <= min_nxt;
				max_q <= max_nxt;
				sum_q <= sum_nxt;
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			slot_out_q <= 2'(slot_q);
			value_q    <= SAMPLE_W'(trimmed / TRIM_DIV);
			done_q     <= done;
		end
	end

	assign out_valid        = out_valid_q;
	assign slot             = slot_out_q;
	assign filtered_value   = value_q;
	assign sweep_done       = done_q;
	assign next_mux_channel = mux_q;

	// count never reaches the window length
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(cnt_q) < SAMPLES)
		else $error("sample count out of range");

	// a result clears the window
	a_window_clear: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (cnt_q == '0) && (sum_q == '0) && out_valid_q)
		else $error("window not cleared after result");

	// min never above max once a window has samples
	a_min_max: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != '0) |-> (min_q <= max_q))
		else $error("running min above running max");

	// the reported channel is always a legal converter input
	a_mux_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (int'(mux_q) <= MAX_CHANNEL))
		else $error("mux channel out of range");

endmodule

[hw/rtl/trimmed_mean_adc_scanner_core.sv]
// top level of the trimmed-mean converter scanner
//
// channel  signals                                   direction  role
// in       in_valid, in_stall, sample                sink       one conversion per beat
// out      out_valid, out_stall, slot, filtered_value,
//          sweep_done, next_mux_channel              source     one beat per full window
// cfg      cfg_valid, cfg_ready, cfg_index, cfg_data sink       mux channel per slot
//
// one sample per cycle unless stalled: one accumulator stage between input and result regs
// the last sample of a window passes the input register, then its result loads the result register
// in_stall rises only when a window ends while an earlier result is still held by out_stall
// arst_n clears the window, slot, mux and valid flags; registers return to channels 0, 1, 2
// cfg_ready is always high; writes take effect on the next window end
module trimmed_mean_adc_scanner_core (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  tmas_pkg::sample_t        sample,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [1:0]               slot,
	output tmas_pkg::sample_t        filtered_value,
	output logic                     sweep_done,
	output tmas_pkg::chan_t          next_mux_channel,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  tmas_pkg::cfg_idx_t       cfg_index,
	input  tmas_pkg::chan_t          cfg_data
);
	import tmas_pkg::*;

	chan_regs_t chans;

	// slot channel registers
	tmas_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.chans     (chans)
	);

	// accumulator datapath
	tmas_accum u_accum (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.sample           (sample),
		.chans            (chans),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.slot             (slot),
		.filtered_value   (filtered_value),
		.sweep_done       (sweep_done),
		.next_mux_channel (next_mux_channel)
	);

endmodule

[dv/trimmed_mean_checker.sv]
// trimmed-mean scanner checker: predicts each window result from accepted beats and compares
`timescale 1ns / 1ps
module trimmed_mean_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  tmas_pkg::sample_t  sample,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [1:0]         slot,
	input  tmas_pkg::sample_t  filtered_value,
	input  logic               sweep_done,
	input  tmas_pkg::chan_t    next_mux_channel,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  tmas_pkg::cfg_idx_t cfg_index,
	input  tmas_pkg::chan_t    cfg_data,
	output int                 errors,
	output int                 pending
);
	import tmas_pkg::*;

	typedef struct packed {
		logic [1:0] slot;
		sample_t    value;
		logic       done;
		chan_t      chan;
	} window_result_t;

	window_result_t expected_windows[$];
	window_result_t want;
	window_result_t got;

	// model copy of the slot registers and the window accumulators
	chan_t       slot_chan [NUM_REGS];
	sample_t     win_min;
	sample_t     win_max;
	logic [15:0] win_sum;
	logic [15:0] trimmed;
	int          win_count;
	int          cur_slot;
	int          next_slot;
	chan_t       mux_sel;
	chan_t       cand;
	int          fail_count = 0;
	int          queued = 0;

	assign errors  = fail_count;
	assign pending = queued;

	task automatic check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				slot_chan[i] = CHAN_RESET[i];
			end
			win_min   = '1;
			win_max   = '0;
			win_sum   = '0;
			win_count = 0;
			cur_slot  = 0;
			mux_sel   = '0;
			expected_windows.delete();
		end else begin
			// register write beat
			if (cfg_valid && cfg_ready && int'(cfg_index) < NUM_REGS) begin
				slot_chan[cfg_index] = cfg_data;
			end

			// sample beat: fold into the window, close it after SAMPLES beats
			if (in_valid && !in_stall) begin
				if (sample > win_max) win_max = sample;
				if (sample < win_min) win_min = sample;
				win_sum = win_sum + 16'(sample);
				win_count++;
				if (win_count >= SAMPLES) begin
					trimmed    = win_sum - 16'(win_min) - 16'(win_max);
					want.slot  = cur_slot[1:0];
					want.value = sample_t'(trimmed / 16'(TRIM_DIV));
					want.done  = (cur_slot >= SLOTS - 1);
					next_slot  = want.done ? 0 : cur_slot + 1;
					cand = (next_slot < NUM_REGS) ? slot_chan[next_slot] : chan_t'(next_slot);
					// a channel above the mux range leaves the selection alone
					if (int'(cand) <= MAX_CHANNEL) mux_sel = cand;
					want.chan  = mux_sel;
					expected_windows.push_back(want);
					win_min   = '1;
					win_max   = '0;
					win_sum   = '0;
					win_count = 0;
					cur_slot  = next_slot;
				end
			end

			// result beat
			if (out_valid && !out_stall) begin
				got = '{slot, filtered_value, sweep_done, next_mux_channel};
				if (expected_windows.size() == 0) begin
					$display("%0t: unexpected result, expected none, got slot %0d value %0d",
						$time, slot, filtered_value);
					fail_count++;
				end else begin
					want = expected_windows.pop_front();
					check_field("slot", want.slot, got.slot);
					check_field("filtered_value", want.value, got.value);
					check_field("sweep_done", want.done, got.done);
					check_field("next_mux_channel", want.chan, got.chan);
				end
			end
		end
		queued = expected_windows.size();
	end

endmodule

[dv/tb_trimmed_mean_adc_scanner_core.sv]
// testbench top for the trimmed-mean converter scanner: stimulus, stalls and verdict
`timescale 1ns / 1ps
module tb_trimmed_mean_adc_scanner_core;
	import tmas_pkg::*;

	localparam int DRAIN_CYCLES = 6;
	localparam int CYCLE_LIMIT  = 400000;

	localparam cfg_idx_t REG_SLOT0 = 2'd0;
	localparam cfg_idx_t REG_SLOT1 = 2'd1;
	localparam cfg_idx_t REG_SLOT2 = 2'd2;
	localparam cfg_idx_t REG_SPARE = 2'd3;	// no register behind this index

	// directed windows: all full scale, then extremes and walking bits, then a partial window
	localparam sample_t DIRECTED [25] = '{
		12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF,
		12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF,
		12'h000, 12'hFFF, 12'hAAA, 12'h555, 12'h001,
		12'h800, 12'h7FF, 12'hFFE, 12'h123, 12'hEDC,
		12'hFFF, 12'h000, 12'h001, 12'h002, 12'h003
	};

	logic       clk;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_stall;
	sample_t    sample    = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [1:0] slot;
	sample_t    filtered_value;
	logic       sweep_done;
	chan_t      next_mux_channel;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	cfg_idx_t   cfg_index = REG_SLOT0;
	chan_t      cfg_data  = '0;

	logic in_beat  = 1'b0;
	logic cfg_beat = 1'b0;
	logic idle_on  = 1'b1;
	int   stall_left = 0;
	int   cycle_count = 0;
	int   errors;
	int   pending;

	trimmed_mean_adc_scanner_core i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.sample           (sample),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.slot             (slot),
		.filtered_value   (filtered_value),
		.sweep_done       (sweep_done),
		.next_mux_channel (next_mux_channel),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	trimmed_mean_checker i_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.sample           (sample),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.slot             (slot),
		.filtered_value   (filtered_value),
		.sweep_done       (sweep_done),
		.next_mux_channel (next_mux_channel),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.errors           (errors),
		.pending          (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// beat flags, read back at the falling edge by the drivers
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_beat  <= 1'b0;
			cfg_beat <= 1'b0;
		end else begin
			in_beat  <= in_valid && !in_stall;
			cfg_beat <= cfg_valid && cfg_ready;
		end
	end

	// result-side stall bursts
	always @(negedge clk) begin
		if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 9);
		end
		if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("trimmed_mean_adc_scanner_core regression: fail");
		$finish;
	end

	function automatic sample_t pick_sample();
		case ($urandom_range(0, 7))
			0: begin
				return $urandom_range(0, 1) ? 12'hFFF : 12'h000;
			end
			1: begin
				return sample_t'($urandom_range(0, 15));
			end
			2: begin
				return sample_t'($urandom_range(4080, 4095));
			end
			default: begin
				return sample_t'($urandom);
			end
		endcase
	endfunction

	task automatic push_sample(input sample_t value);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		in_valid <= 1'b1;
		sample   <= value;
		do @(negedge clk); while (!in_beat);
	endtask

	task automatic run_random(input int count);
		for (int n = 0; n < count; n++) begin
			push_sample(pick_sample());
		end
	endtask

	// hold off the sender until every window result is out, then let the pipe settle
	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input chan_t value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(negedge clk); while (!cfg_beat);
	endtask

	task automatic load_channels(input chan_t c0, input chan_t c1, input chan_t c2,
		input chan_t spare);
		write_reg(REG_SLOT0, c0);
		write_reg(REG_SLOT1, c1);
		write_reg(REG_SLOT2, c2);
		write_reg(REG_SPARE, spare);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed part on the reset channel map, ending mid-window
		foreach (DIRECTED[k]) begin
			push_sample(DIRECTED[k]);
		end
		drain();

		// channels above the mux range must leave the selection unchanged
		load_channels(4'd15, 4'd9, 4'd8, 4'd15);
		run_random(240);
		drain();

		load_channels(4'd0, 4'd8, 4'd15, 4'd0);
		run_random(240);
		drain();

		load_channels(chan_t'($urandom_range(0, 15)), chan_t'($urandom_range(0, 15)),
			chan_t'($urandom_range(0, 15)), chan_t'($urandom_range(0, 15)));
		run_random(240);
		drain();

		// closing stretch runs at full rate on both sides
		idle_on <= 1'b0;
		load_channels(4'd8, 4'd12, 4'd0, chan_t'($urandom_range(0, 15)));
		run_random(230);
		drain();

		if (errors == 0 && pending == 0) begin
			$display("trimmed_mean_adc_scanner_core regression: pass");
		end else begin
			$display("trimmed_mean_adc_scanner_core regression: fail");
		end
		$finish;
	end

endmodule

[sim.f]
hw/rtl/tmas_pkg.sv
hw/rtl/tmas_cfg_regs.sv
hw/rtl/tmas_accum.sv
hw/rtl/trimmed_mean_adc_scanner_core.sv
dv/trimmed_mean_checker.sv
dv/tb_trimmed_mean_adc_scanner_core.sv
